### rtl/core/btess_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btess_pkg
// Types and constants shared by the ribbon tessellator core.
// ---------------------------------------------------------------------------
package btess_pkg;

    localparam int STEP_W     = 5;
    localparam int COORD_W    = 16;
    localparam int WIDTH_W    = 16;
    localparam int GAIN_W     = 8;
    localparam int FLOW_W     = 16;
    localparam int COLOR_W    = 24;
    localparam int ALPHA_W    = 8;
    localparam int CX_W       = 21;
    localparam int TAN_W      = 30;
    localparam int NORM_W     = 30;
    localparam int RAD_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int QUO_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int VERT_W     = CX_W + 1;

    localparam logic [ALPHA_W-1:0]    VERTEX_ALPHA   = 8'd200;
    localparam logic [WIDTH_W-1:0]    MIN_WIDTH_RST  = 16'd80;
    localparam logic [GAIN_W-1:0]     WIDTH_GAIN_RST = 8'd20;
    localparam logic [CFG_IDX_W-1:0]  REG_MIN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_WIDTH_GAIN = 1'd1;

    // Data that rides alongside the normalisation pipeline
    typedef struct packed {
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
        logic                   neg_ox;
        logic                   neg_oy;
        logic                   zero;
        logic [COLOR_W-1:0]     color;
        logic                   last;
    } side_t;

    function automatic logic [COORD_W-1:0] sat16(input logic signed [VERT_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > VERT_W'(32767)) begin
            r = 16'h7FFF;
        end else if (v < -VERT_W'(32768)) begin
            r = 16'h8000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/btess_norm.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btess_norm
// Pipelined normal scaling: length by bit-serial square root, one root bit
// per stage, then offset = mag * width / (2 * length) by restoring division,
// one quotient bit per stage.
// ---------------------------------------------------------------------------
module btess_norm
    import btess_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [NORM_W-1:0]   in_mx,
    input  logic [NORM_W-1:0]   in_my,
    input  logic [WIDTH_W-1:0]  in_w,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [QUO_W-1:0]    out_qx,
    output logic [QUO_W-1:0]    out_qy,
    output side_t               out_side
);

    localparam int DIV_W = 48;

    // squares
    logic                sq_valid_reg;
    logic [2*NORM_W-1:0] sqx_reg, sqy_reg;
    logic [NORM_W-1:0]   sq_mx_reg, sq_my_reg;
    logic [WIDTH_W-1:0]  sq_w_reg;
    side_t               sq_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (adv) begin
            sq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg     <= in_mx * in_mx;
            sqy_reg     <= in_my * in_my;
            sq_mx_reg   <= in_mx;
            sq_my_reg   <= in_my;
            sq_w_reg    <= in_w;
            sq_side_reg <= in_side;
        end
    end

    // root stages: index 0 is the radicand stage
    logic                rt_valid_reg [0:ROOT_W];
    logic [RAD_W-1:0]    rt_rem_reg   [0:ROOT_W];
    logic [ROOT_W-1:0]   rt_root_reg  [0:ROOT_W];
    logic [NORM_W-1:0]   rt_mx_reg    [0:ROOT_W];
    logic [NORM_W-1:0]   rt_my_reg    [0:ROOT_W];
    logic [WIDTH_W-1:0]  rt_w_reg     [0:ROOT_W];
    side_t               rt_side_reg  [0:ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            rt_valid_reg[0] <= sq_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rt_rem_reg[0]  <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
            rt_root_reg[0] <= '0;
            rt_mx_reg[0]   <= sq_mx_reg;
            rt_my_reg[0]   <= sq_my_reg;
            rt_w_reg[0]    <= sq_w_reg;
            rt_side_reg[0] <= sq_side_reg;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_root
        localparam int K = ROOT_W - 1 - j;
        logic [RAD_W-1:0] trial;

        assign trial = (RAD_W'(rt_root_reg[j]) << (K + 1)) + (RAD_W'(1) << (2 * K));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_valid_reg[j+1] <= 1'b0;
            end else if (adv) begin
                rt_valid_reg[j+1] <= rt_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                if (rt_rem_reg[j] >= trial) begin
                    rt_rem_reg[j+1]  <= rt_rem_reg[j] - trial;
                    rt_root_reg[j+1] <= rt_root_reg[j] | (ROOT_W'(1) << K);
                end else begin
                    rt_rem_reg[j+1]  <= rt_rem_reg[j];
                    rt_root_reg[j+1] <= rt_root_reg[j];
                end
                rt_mx_reg[j+1]   <= rt_mx_reg[j];
                rt_my_reg[j+1]   <= rt_my_reg[j];
                rt_w_reg[j+1]    <= rt_w_reg[j];
                rt_side_reg[j+1] <= rt_side_reg[j];
            end
        end
    end

    // division stages: index 0 holds numerator and divisor
    logic                dv_valid_reg [0:QUO_W];
    logic [DIV_W-1:0]    dv_remx_reg  [0:QUO_W];
    logic [DIV_W-1:0]    dv_remy_reg  [0:QUO_W];
    logic [ROOT_W:0]     dv_den_reg   [0:QUO_W];
    logic [QUO_W-1:0]    dv_qx_reg    [0:QUO_W];
    logic [QUO_W-1:0]    dv_qy_reg    [0:QUO_W];
    side_t               dv_side_reg  [0:QUO_W];

    logic [NORM_W+WIDTH_W-1:0] prod_x, prod_y;
    logic [ROOT_W-1:0]         len;

    assign len    = rt_root_reg[ROOT_W];
    assign prod_x = rt_mx_reg[ROOT_W] * rt_w_reg[ROOT_W];
    assign prod_y = rt_my_reg[ROOT_W] * rt_w_reg[ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_valid_reg[0] <= rt_valid_reg[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_remx_reg[0] <= DIV_W'(prod_x) + DIV_W'(len);
            dv_remy_reg[0] <= DIV_W'(prod_y) + DIV_W'(len);
            dv_den_reg[0]  <= {len, 1'b0};
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            dv_side_reg[0] <= rt_side_reg[ROOT_W];
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int K = QUO_W - 1 - j;
        logic [DIV_W-1:0] dsh;

        assign dsh = DIV_W'(dv_den_reg[j]) << K;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j+1] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                if (dv_remx_reg[j] >= dsh) begin
                    dv_remx_reg[j+1] <= dv_remx_reg[j] - dsh;
                    dv_qx_reg[j+1]   <= dv_qx_reg[j] | (QUO_W'(1) << K);
                end else begin
                    dv_remx_reg[j+1] <= dv_remx_reg[j];
                    dv_qx_reg[j+1]   <= dv_qx_reg[j];
                end
                if (dv_remy_reg[j] >= dsh) begin
                    dv_remy_reg[j+1] <= dv_remy_reg[j] - dsh;
                    dv_qy_reg[j+1]   <= dv_qy_reg[j] | (QUO_W'(1) << K);
                end else begin
                    dv_remy_reg[j+1] <= dv_remy_reg[j];
                    dv_qy_reg[j+1]   <= dv_qy_reg[j];
                end
                dv_den_reg[j+1]  <= dv_den_reg[j];
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    assign out_valid = dv_valid_reg[QUO_W];
    assign out_qx    = dv_qx_reg[QUO_W];
    assign out_qy    = dv_qy_reg[QUO_W];
    assign out_side  = dv_side_reg[QUO_W];

endmodule

### rtl/core/bezier_ribbon_tessellator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bezier_ribbon_tessellator
// Cubic Bezier link to triangle-strip ribbon vertices.
// ---------------------------------------------------------------------------
// Each link transfer yields 2*(SEGMENTS+1) vertices (62 at the default),
// top then bottom per sample, m_tlast on the final bottom one. The
// result channel gives one vertex per cycle while m_tready holds. The
// next link is taken as the last sample of the current one enters the
// pipeline. Samples run through a deep pipeline (weights, products, sums,
// normalisation, a 31-stage square root and a 16-stage divider). Width
// registers are sampled at the link transfer.
// ---------------------------------------------------------------------------
module bezier_ribbon_tessellator
    import btess_pkg::*;
#(
    parameter int SEGMENTS = 30
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x, start_y, pull1_x, pull1_y, pull2_x, pull2_y, end_x, end_y,
    // flow_value, ribbon_color
    input  logic [167:0]          s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // vertex_x, vertex_y, vertex_color, vertex_alpha
    output logic [63:0]           m_tdata,
    output logic                  m_tlast,
    // edge_side
    output logic                  m_tuser
);

    localparam int TAB_N = 2 ** STEP_W;
    localparam int S3    = SEGMENTS * SEGMENTS * SEGMENTS;
    localparam int HALF  = S3 / 2;

    // configuration
    logic [WIDTH_W-1:0] min_width_reg;
    logic [GAIN_W-1:0]  width_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_width_reg  <= MIN_WIDTH_RST;
            width_gain_reg <= WIDTH_GAIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_WIDTH:  min_width_reg  <= cfg_wr_data;
                REG_WIDTH_GAIN: width_gain_reg <= cfg_wr_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // sample tables
    logic [16:0] tab_w0 [0:TAB_N-1];
    logic [16:0] tab_w1 [0:TAB_N-1];
    logic [16:0] tab_w2 [0:TAB_N-1];
    logic [16:0] tab_w3 [0:TAB_N-1];
    logic [9:0]  tab_c0 [0:TAB_N-1];
    logic [9:0]  tab_c1 [0:TAB_N-1];
    logic [9:0]  tab_c2 [0:TAB_N-1];

    for (genvar g = 0; g < TAB_N; g++) begin : g_tab
        if (g <= SEGMENTS) begin : g_used
            localparam int U  = SEGMENTS - g;
            localparam int W0 = (U * U * U * 32768 + HALF) / S3;
            localparam int W1 = (3 * U * U * g * 32768 + HALF) / S3;
            localparam int W2 = (3 * U * g * g * 32768 + HALF) / S3;
            localparam int W3 = (g * g * g * 32768 + HALF) / S3;
            assign tab_w0[g] = 17'(W0);
            assign tab_w1[g] = 17'(W1);
            assign tab_w2[g] = 17'(W2);
            assign tab_w3[g] = 17'(W3);
            assign tab_c0[g] = 10'(U * U);
            assign tab_c1[g] = 10'(2 * U * g);
            assign tab_c2[g] = 10'(g * g);
        end else begin : g_unused
            assign tab_w0[g] = '0;
            assign tab_w1[g] = '0;
            assign tab_w2[g] = '0;
            assign tab_w3[g] = '0;
            assign tab_c0[g] = '0;
            assign tab_c1[g] = '0;
            assign tab_c2[g] = '0;
        end
    end

    // output register and global advance
    logic                out_valid_reg, out_side_reg, out_last_reg;
    logic [COORD_W-1:0]  top_x_reg, top_y_reg, bot_x_reg, bot_y_reg;
    logic [COLOR_W-1:0]  out_color_reg;
    logic                adv;

    assign adv = !out_valid_reg || (m_tready && out_side_reg);

    // link sequencer
    logic                       link_active_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [COORD_W-1:0]  hx_reg [0:3];
    logic signed [COORD_W-1:0]  hy_reg [0:3];
    logic [WIDTH_W-1:0]         hw_reg;
    logic [COLOR_W-1:0]         hcolor_reg;
    logic                       issue, last_step, accept;
    logic [FLOW_W+GAIN_W:0]     wprod;
    logic [FLOW_W+GAIN_W-4:0]   wround;
    logic [WIDTH_W-1:0]         w_next;

    assign issue     = link_active_reg && adv;
    assign last_step = (step_reg == STEP_W'(SEGMENTS));
    assign s_tready  = !link_active_reg || (adv && last_step);
    assign accept    = s_tvalid && s_tready;

    assign wprod  = (FLOW_W+GAIN_W+1)'(s_tdata[143:128])
                    * (FLOW_W+GAIN_W+1)'(width_gain_reg)
                    + (FLOW_W+GAIN_W+1)'(8);
    assign wround = wprod[FLOW_W+GAIN_W:4];

    always_comb begin
        if (wround < (FLOW_W+GAIN_W-3)'(min_width_reg)) begin
            w_next = min_width_reg;
        end else if (wround > (FLOW_W+GAIN_W-3)'(16'hFFFF)) begin
            w_next = 16'hFFFF;
        end else begin
            w_next = wround[WIDTH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_active_reg <= 1'b0;
            step_reg        <= '0;
        end else if (accept) begin
            link_active_reg <= 1'b1;
            step_reg        <= '0;
        end else if (issue) begin
            if (last_step) begin
                link_active_reg <= 1'b0;
                step_reg        <= '0;
            end else begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < 4; k++) begin
                hx_reg[k] <= s_tdata[32*k +: 16];
                hy_reg[k] <= s_tdata[32*k+16 +: 16];
            end
            hw_reg     <= w_next;
            hcolor_reg <= s_tdata[167:144];
        end
    end

    // stage A: table lookup, control point differences
    logic                      a_valid_reg, a_last_reg;
    logic [16:0]               a_wt_reg [0:3];
    logic [9:0]                a_c_reg  [0:2];
    logic signed [COORD_W:0]   a_dx_reg [0:2];
    logic signed [COORD_W:0]   a_dy_reg [0:2];
    logic signed [COORD_W-1:0] a_px_reg [0:3];
    logic signed [COORD_W-1:0] a_py_reg [0:3];
    logic [WIDTH_W-1:0]        a_w_reg;
    logic [COLOR_W-1:0]        a_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_wt_reg[0] <= tab_w0[step_reg];
            a_wt_reg[1] <= tab_w1[step_reg];
            a_wt_reg[2] <= tab_w2[step_reg];
            a_wt_reg[3] <= tab_w3[step_reg];
            a_c_reg[0]  <= tab_c0[step_reg];
            a_c_reg[1]  <= tab_c1[step_reg];
            a_c_reg[2]  <= tab_c2[step_reg];
            for (int k = 0; k < 3; k++) begin
                a_dx_reg[k] <= (COORD_W+1)'(hx_reg[k+1]) - (COORD_W+1)'(hx_reg[k]);
                a_dy_reg[k] <= (COORD_W+1)'(hy_reg[k+1]) - (COORD_W+1)'(hy_reg[k]);
            end
            for (int k = 0; k < 4; k++) begin
                a_px_reg[k] <= hx_reg[k];
                a_py_reg[k] <= hy_reg[k];
            end
            a_w_reg     <= hw_reg;
            a_color_reg <= hcolor_reg;
            a_last_reg  <= last_step;
        end
    end

    // stage B: products
    logic               b_valid_reg, b_last_reg;
    logic signed [33:0] b_px_reg [0:3];
    logic signed [33:0] b_py_reg [0:3];
    logic signed [27:0] b_tx_reg [0:2];
    logic signed [27:0] b_ty_reg [0:2];
    logic [WIDTH_W-1:0] b_w_reg;
    logic [COLOR_W-1:0] b_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                b_px_reg[k] <= $signed({1'b0, a_wt_reg[k]}) * a_px_reg[k];
                b_py_reg[k] <= $signed({1'b0, a_wt_reg[k]}) * a_py_reg[k];
            end
            for (int k = 0; k < 3; k++) begin
                b_tx_reg[k] <= $signed({1'b0, a_c_reg[k]}) * a_dx_reg[k];
                b_ty_reg[k] <= $signed({1'b0, a_c_reg[k]}) * a_dy_reg[k];
            end
            b_w_reg     <= a_w_reg;
            b_color_reg <= a_color_reg;
            b_last_reg  <= a_last_reg;
        end
    end

    // stage C: sums, round the point
    logic                    c_valid_reg, c_last_reg;
    logic signed [CX_W-1:0]  c_cx_reg, c_cy_reg;
    logic signed [TAN_W-1:0] c_tx_reg, c_ty_reg;
    logic [WIDTH_W-1:0]      c_w_reg;
    logic [COLOR_W-1:0]      c_color_reg;
    logic signed [35:0]      sum_x, sum_y;

    assign sum_x = 36'(b_px_reg[0]) + 36'(b_px_reg[1]) + 36'(b_px_reg[2])
                 + 36'(b_px_reg[3]) + 36'sd16384;
    assign sum_y = 36'(b_py_reg[0]) + 36'(b_py_reg[1]) + 36'(b_py_reg[2])
                 + 36'(b_py_reg[3]) + 36'sd16384;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_cx_reg    <= sum_x[35:15];
            c_cy_reg    <= sum_y[35:15];
            c_tx_reg    <= TAN_W'(b_tx_reg[0]) + TAN_W'(b_tx_reg[1]) + TAN_W'(b_tx_reg[2]);
            c_ty_reg    <= TAN_W'(b_ty_reg[0]) + TAN_W'(b_ty_reg[1]) + TAN_W'(b_ty_reg[2]);
            c_w_reg     <= b_w_reg;
            c_color_reg <= b_color_reg;
            c_last_reg  <= b_last_reg;
        end
    end

    // stage D: magnitudes and signs
    logic               d_valid_reg;
    logic [NORM_W-1:0]  d_mx_reg, d_my_reg;
    logic [WIDTH_W-1:0] d_w_reg;
    side_t              d_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_mx_reg          <= c_tx_reg[TAN_W-1] ? NORM_W'(-c_tx_reg) : NORM_W'(c_tx_reg);
            d_my_reg          <= c_ty_reg[TAN_W-1] ? NORM_W'(-c_ty_reg) : NORM_W'(c_ty_reg);
            d_w_reg           <= c_w_reg;
            d_side_reg.cx     <= c_cx_reg;
            d_side_reg.cy     <= c_cy_reg;
            d_side_reg.neg_ox <= !c_ty_reg[TAN_W-1] && (c_ty_reg != '0);
            d_side_reg.neg_oy <= c_tx_reg[TAN_W-1];
            d_side_reg.zero   <= (c_tx_reg == '0) && (c_ty_reg == '0);
            d_side_reg.color  <= c_color_reg;
            d_side_reg.last   <= c_last_reg;
        end
    end

    // stage E: leading zero count of the larger magnitude
    logic               e_valid_reg;
    logic [NORM_W-1:0]  e_mx_reg, e_my_reg;
    logic [4:0]         e_sh_reg;
    logic [WIDTH_W-1:0] e_w_reg;
    side_t              e_side_reg;
    logic [NORM_W-1:0]  mor;
    logic [4:0]         lz;

    assign mor = d_mx_reg | d_my_reg;

    always_comb begin
        lz = '0;
        for (int b = 0; b < NORM_W; b++) begin
            if (mor[b]) begin
                lz = 5'(NORM_W - 1 - b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_mx_reg   <= d_mx_reg;
            e_my_reg   <= d_my_reg;
            e_sh_reg   <= lz;
            e_w_reg    <= d_w_reg;
            e_side_reg <= d_side_reg;
        end
    end

    // stage F: normalise
    logic               f_valid_reg;
    logic [NORM_W-1:0]  f_mx_reg, f_my_reg;
    logic [WIDTH_W-1:0] f_w_reg;
    side_t              f_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_mx_reg   <= e_mx_reg << e_sh_reg;
            f_my_reg   <= e_my_reg << e_sh_reg;
            f_w_reg    <= e_w_reg;
            f_side_reg <= e_side_reg;
        end
    end

    // length and scaled offsets
    logic             n_valid;
    logic [QUO_W-1:0] n_qx, n_qy;
    side_t            n_side;

    btess_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid_reg),
        .in_mx     (f_mx_reg),
        .in_my     (f_my_reg),
        .in_w      (f_w_reg),
        .in_side   (f_side_reg),
        .out_valid (n_valid),
        .out_qx    (n_qx),
        .out_qy    (n_qy),
        .out_side  (n_side)
    );

    // vertices: offset x comes from |Ty|, offset y from |Tx|
    logic signed [QUO_W:0]   ox, oy;
    logic signed [VERT_W-1:0] tx_sum, ty_sum, bx_sum, by_sum;

    always_comb begin
        if (n_side.zero) begin
            ox = '0;
            oy = '0;
        end else begin
            ox = n_side.neg_ox ? -$signed({1'b0, n_qy}) : $signed({1'b0, n_qy});
            oy = n_side.neg_oy ? -$signed({1'b0, n_qx}) : $signed({1'b0, n_qx});
        end
    end

    assign tx_sum = VERT_W'(n_side.cx) + VERT_W'(ox);
    assign ty_sum = VERT_W'(n_side.cy) + VERT_W'(oy);
    assign bx_sum = VERT_W'(n_side.cx) - VERT_W'(ox);
    assign by_sum = VERT_W'(n_side.cy) - VERT_W'(oy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_side_reg  <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= n_valid;
            out_side_reg  <= 1'b0;
        end else if (m_tready) begin
            // top vertex gone, present the bottom one
            out_side_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            top_x_reg     <= sat16(tx_sum);
            top_y_reg     <= sat16(ty_sum);
            bot_x_reg     <= sat16(bx_sum);
            bot_y_reg     <= sat16(by_sum);
            out_color_reg <= n_side.color;
            out_last_reg  <= n_side.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_side_reg;
    assign m_tlast  = out_last_reg && out_side_reg;
    assign m_tdata  = {VERTEX_ALPHA, out_color_reg,
                       out_side_reg ? bot_y_reg : top_y_reg,
                       out_side_reg ? bot_x_reg : top_x_reg};

endmodule
